// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the max-flow block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property that must hold at every clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Implication on the next cycle, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication on the next cycle, checked during reset as well.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mfek_pkg.sv =====
// Package for the max-flow block: default sizes, field widths, constants,
// controller state and command encodings and the status bundle. No dependencies.
package mfek_pkg;

   localparam int DEF_MAX_NODES = 512;
   localparam int DEF_MAX_EDGES = 1024;

   localparam int NODE_FIELD_W = 10;
   localparam int CAP_W        = 30;
   localparam int FLOW_W       = 40;

   localparam logic [CAP_W-1:0]  CAP_LIMIT = 30'd1000000000;
   localparam logic [FLOW_W-1:0] FLOW_MAX  = 40'hFF_FFFF_FFFF;
   localparam logic [NODE_FIELD_W-1:0] NODE_COUNT_RESET = 10'd2;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_CLR_LIST,
      OP_TAKE,
      OP_LINK_A,
      OP_LINK_B,
      OP_CLR_VIS,
      OP_POP,
      OP_SINK_RD,
      OP_HEAD,
      OP_FIRST,
      OP_EDGE,
      OP_VISIT,
      OP_PATH_INIT,
      OP_PATH_INIT2,
      OP_PAR_RD,
      OP_CAP_RD,
      OP_MIN,
      OP_AUG,
      OP_ADD
   } op_type;

   typedef enum logic [4:0] {
      ST_CLR_LIST,
      ST_LOAD,
      ST_LINK_A,
      ST_LINK_B,
      ST_CLR_VIS,
      ST_POP,
      ST_HEAD,
      ST_FIRST,
      ST_EDGE,
      ST_VISIT,
      ST_CHECK,
      ST_MIN_INIT,
      ST_MIN_PAR,
      ST_MIN_CAP,
      ST_MIN_STEP,
      ST_AUG_INIT,
      ST_AUG_PAR,
      ST_AUG_CAP,
      ST_AUG_STEP,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic take_ok;
      logic req_last;
      logic item_last;
      logic clr_last;
      logic vis_last;
      logic q_empty;
      logic first_end;
      logic next_end;
      logic sink_seen;
      logic path_done;
   } status_type;

endpackage

// ===== hw/rtl/max_flow_edmonds_karp.sv =====
// Top level of the max-flow block: controller and datapath with assertions.
// Depends on mfek_pkg, mfek_ctrl, mfek_datapath and assert_macros.svh.
//
//   Channel  Direction  Handshake        Contents
//   req      in         valid / ready    from_node, to_node, capacity, last_edge
//   rsp      out        valid / ready    total_flow
//   csr      in         write enable     node_count
//
// A stored edge runs take, link forward and link reverse; a dropped edge only take.
// Each search clears all n visited marks, then per dequeued node pops and reads its
// list head and first entry, per scanned entry reads the edge and visits; each path
// is walked for the minimum, then to augment. After reset and each delivered result
// a clearing pass, taking no transaction, resets all MAX_NODES adjacency lists.
// The result is held until rsp_ready; no input is taken while it waits.
`include "assert_macros.svh"

module max_flow_edmonds_karp
   import mfek_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [NODE_FIELD_W-1:0] csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [NODE_FIELD_W-1:0] req_from_node,
   input  logic [NODE_FIELD_W-1:0] req_to_node,
   input  logic [CAP_W-1:0]        req_capacity,
   input  logic                    req_last_edge,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [FLOW_W-1:0]       rsp_total_flow
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   mfek_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Memories and arithmetic.
   mfek_datapath #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_from_node  (req_from_node),
      .req_to_node    (req_to_node),
      .req_capacity   (req_capacity),
      .req_last_edge  (req_last_edge),
      .rsp_total_flow (rsp_total_flow)
   );

   // The block never offers a result while it takes input.
   `ASSERT_NEVER(a_ready_vs_valid, clock, reset, req_ready && rsp_valid, "ready during result")
   // A delivered result is followed by the clearing pass.
   `ASSERT_NEXT(a_clear_after_rsp, clock, reset, rsp_valid && rsp_ready, !req_ready, "no clear pass")
   // Reset starts the clearing pass.
   `ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !req_ready && !rsp_valid, "busy after reset")
   // A stored edge is linked before the next transaction is taken.
   `ASSERT_NEXT(a_link_gap, clock, reset, cmd.op == OP_TAKE && status.take_ok, !req_ready, "link gap")

endmodule

// ===== hw/rtl/mfek_ctrl.sv =====
// Controller state machine of the max-flow block: sequences loading,
// breadth-first search, augmentation and result delivery. Uses mfek_pkg.
module mfek_ctrl
   import mfek_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_LIST;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_IDLE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLR_LIST: begin
            cmd.op = OP_CLR_LIST;
            if (status.clr_last) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_TAKE;
               if (status.take_ok) state_in = ST_LINK_A;
               else if (status.req_last) state_in = ST_CLR_VIS;
            end
         end
         ST_LINK_A: begin
            cmd.op   = OP_LINK_A;
            state_in = ST_LINK_B;
         end
         ST_LINK_B: begin
            cmd.op   = OP_LINK_B;
            state_in = status.item_last ? ST_CLR_VIS : ST_LOAD;
         end
         ST_CLR_VIS: begin
            cmd.op = OP_CLR_VIS;
            if (status.vis_last) state_in = ST_POP;
         end
         ST_POP: begin
            if (status.q_empty) begin
               cmd.op   = OP_SINK_RD;
               state_in = ST_CHECK;
            end else begin
               cmd.op   = OP_POP;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.op   = OP_HEAD;
            state_in = ST_FIRST;
         end
         ST_FIRST: begin
            cmd.op   = OP_FIRST;
            state_in = status.first_end ? ST_POP : ST_EDGE;
         end
         ST_EDGE: begin
            cmd.op   = OP_EDGE;
            state_in = ST_VISIT;
         end
         ST_VISIT: begin
            cmd.op   = OP_VISIT;
            state_in = status.next_end ? ST_POP : ST_EDGE;
         end
         ST_CHECK: begin
            state_in = status.sink_seen ? ST_MIN_INIT : ST_OUT;
         end
         ST_MIN_INIT: begin
            cmd.op   = OP_PATH_INIT;
            state_in = ST_MIN_PAR;
         end
         ST_MIN_PAR: begin
            if (status.path_done) begin
               state_in = ST_AUG_INIT;
            end else begin
               cmd.op   = OP_PAR_RD;
               state_in = ST_MIN_CAP;
            end
         end
         ST_MIN_CAP: begin
            cmd.op   = OP_CAP_RD;
            state_in = ST_MIN_STEP;
         end
         ST_MIN_STEP: begin
            cmd.op   = OP_MIN;
            state_in = ST_MIN_PAR;
         end
         ST_AUG_INIT: begin
            cmd.op   = OP_PATH_INIT2;
            state_in = ST_AUG_PAR;
         end
         ST_AUG_PAR: begin
            if (status.path_done) begin
               state_in = ST_ADD;
            end else begin
               cmd.op   = OP_PAR_RD;
               state_in = ST_AUG_CAP;
            end
         end
         ST_AUG_CAP: begin
            cmd.op   = OP_CAP_RD;
            state_in = ST_AUG_STEP;
         end
         ST_AUG_STEP: begin
            cmd.op   = OP_AUG;
            state_in = ST_AUG_PAR;
         end
         ST_ADD: begin
            cmd.op   = OP_ADD;
            state_in = ST_CLR_VIS;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_CLR_LIST;
         end
         default: begin
            state_in = ST_CLR_LIST;
         end
      endcase
   end

endmodule

// ===== hw/rtl/mfek_datapath.sv =====
// Datapath of the max-flow block: edge, list, search and path memories,
// counters and arithmetic, driven by commands from mfek_ctrl. Uses mfek_pkg.
module mfek_datapath
   import mfek_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    csr_wr_en,
   input  logic [NODE_FIELD_W-1:0] csr_wr_data,
   input  logic [NODE_FIELD_W-1:0] req_from_node,
   input  logic [NODE_FIELD_W-1:0] req_to_node,
   input  logic [CAP_W-1:0]        req_capacity,
   input  logic                    req_last_edge,
   output logic [FLOW_W-1:0]       rsp_total_flow
);

   localparam int NW   = $clog2(MAX_NODES);
   localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int SW   = EW + 1;
   localparam int LW   = SW + 1;
   localparam int CNTW = $clog2(MAX_EDGES + 1);
   localparam logic [LW-1:0]   NO_EDGE   = LW'(2 * MAX_EDGES);
   localparam logic [NW-1:0]   LAST_NODE = NW'(MAX_NODES - 1);
   localparam logic [CNTW-1:0] EDGE_FULL = CNTW'(MAX_EDGES);

   // Memories.
   logic [NW-1:0]    ends_a_mem [MAX_EDGES];
   logic [NW-1:0]    ends_b_mem [MAX_EDGES];
   logic [CAP_W-1:0] cap_e_mem  [MAX_EDGES];
   logic [CAP_W-1:0] cap_o_mem  [MAX_EDGES];
   logic [LW-1:0]    next_e_mem [MAX_EDGES];
   logic [LW-1:0]    next_o_mem [MAX_EDGES];
   logic [LW-1:0]    lh_mem     [MAX_NODES];
   logic             vis_mem    [MAX_NODES];
   logic [SW-1:0]    par_mem    [MAX_NODES];
   logic [NW-1:0]    q_mem      [MAX_NODES];

   // Registered read data.
   logic [NW-1:0]    a_q, b_q;
   logic [CAP_W-1:0] ce_q, co_q;
   logic [LW-1:0]    ne_q, no_q, lh_q0, lh_q1;
   logic             vis_q;
   logic [SW-1:0]    par_q;
   logic [NW-1:0]    q_q;

   // Control and working registers.
   logic [NODE_FIELD_W-1:0] csr_ff;
   logic [NW-1:0]    item_a_ff, item_b_ff;
   logic [CAP_W-1:0] item_c_ff;
   logic             item_last_ff;
   logic [CNTW-1:0]  edges_ff;
   logic [FLOW_W-1:0] flow_ff;
   logic [NW-1:0]    sweep_ff;
   logic [NW:0]      qh_ff, qt_ff;
   logic [LW-1:0]    ei_ff;
   logic [NW-1:0]    u_ff;
   logic [NW:0]      steps_ff;
   logic [CAP_W-1:0] mf_ff;

   logic [31:0]      cfg_w;
   logic [NW:0]      n_eff;
   logic [NW-1:0]    sink;
   logic [NW-1:0]    a_idx, b_idx;
   logic [CAP_W-1:0] cap_sat;
   logic [EW-1:0]    k_idx;
   logic             par_bit;
   logic [NW-1:0]    v_node, tail_node;
   logic [CAP_W-1:0] cap_sel;
   logic [LW-1:0]    next_sel;
   logic             vis_take;
   logic [FLOW_W:0]  flow_sum;

   logic             lh_we;
   logic [NW-1:0]    lh_wa, lh_ra0;
   logic [LW-1:0]    lh_wd;
   logic             cap_we;
   logic [EW-1:0]    cap_wa, pair_ra;
   logic [CAP_W-1:0] cap_e_wd, cap_o_wd;
   logic             vis_we, vis_wd;
   logic [NW-1:0]    vis_wa, vis_ra;
   logic             q_we;
   logic [NW-1:0]    q_wa, q_wd;

   // Effective node count and item checks.
   always_comb begin
      cfg_w = 32'(csr_ff);
      if (cfg_w < 32'd2) n_eff = (NW+1)'(2);
      else if (cfg_w > 32'(MAX_NODES)) n_eff = (NW+1)'(MAX_NODES);
      else n_eff = (NW+1)'(cfg_w);
   end
   assign sink    = NW'(n_eff - (NW+1)'(1));
   assign a_idx   = NW'(req_from_node - 10'd1);
   assign b_idx   = NW'(req_to_node - 10'd1);
   assign cap_sat = (req_capacity > CAP_LIMIT) ? CAP_LIMIT : req_capacity;
   assign k_idx   = edges_ff[EW-1:0];

   // Edge decode: even slots run tail a to head b, odd slots the reverse.
   assign par_bit   = ei_ff[0];
   assign v_node    = par_bit ? a_q : b_q;
   assign tail_node = par_bit ? b_q : a_q;
   assign cap_sel   = par_bit ? co_q : ce_q;
   assign next_sel  = par_bit ? no_q : ne_q;
   assign vis_take  = (cap_sel != '0) && ({1'b0, v_node} < n_eff) && !vis_q && (qt_ff < n_eff);
   assign flow_sum  = {1'b0, flow_ff} + (FLOW_W+1)'(mf_ff);

   // Status toward the controller.
   always_comb begin
      status.take_ok   = (req_from_node != '0) && (32'(req_from_node) <= 32'(n_eff)) &&
                         (req_to_node != '0) && (32'(req_to_node) <= 32'(n_eff)) &&
                         (edges_ff < EDGE_FULL);
      status.req_last  = req_last_edge;
      status.item_last = item_last_ff;
      status.clr_last  = (sweep_ff == LAST_NODE);
      status.vis_last  = (sweep_ff == sink);
      status.q_empty   = (qh_ff == qt_ff);
      status.first_end = (lh_q0 >= NO_EDGE);
      status.next_end  = (next_sel >= NO_EDGE);
      status.sink_seen = vis_q;
      status.path_done = (u_ff == '0) || (steps_ff >= n_eff);
   end

   // Memory addresses and write controls.
   always_comb begin
      lh_we    = 1'b0;
      lh_wa    = sweep_ff;
      lh_wd    = NO_EDGE;
      lh_ra0   = (cmd.op == OP_TAKE) ? a_idx : q_q;
      cap_we   = 1'b0;
      cap_wa   = ei_ff[SW-1:1];
      cap_e_wd = item_c_ff;
      cap_o_wd = '0;
      vis_we   = 1'b0;
      vis_wa   = sweep_ff;
      vis_wd   = (sweep_ff == '0);
      vis_ra   = (cmd.op == OP_SINK_RD) ? sink : v_node;
      q_we     = 1'b0;
      q_wa     = '0;
      q_wd     = '0;
      pair_ra  = ei_ff[SW-1:1];
      case (cmd.op)
         OP_CLR_LIST: begin
            lh_we = 1'b1;
         end
         OP_LINK_A: begin
            lh_we  = 1'b1;
            lh_wa  = item_a_ff;
            lh_wd  = {1'b0, k_idx, 1'b0};
            cap_we = 1'b1;
            cap_wa = k_idx;
         end
         OP_LINK_B: begin
            lh_we = 1'b1;
            lh_wa = item_b_ff;
            lh_wd = {1'b0, k_idx, 1'b1};
         end
         OP_CLR_VIS: begin
            vis_we = 1'b1;
            q_we   = 1'b1;
         end
         OP_FIRST: begin
            pair_ra = lh_q0[SW-1:1];
         end
         OP_VISIT: begin
            pair_ra = next_sel[SW-1:1];
            vis_we  = vis_take;
            vis_wa  = v_node;
            vis_wd  = 1'b1;
            q_we    = vis_take;
            q_wa    = qt_ff[NW-1:0];
            q_wd    = v_node;
         end
         OP_CAP_RD: begin
            pair_ra = par_q[SW-1:1];
         end
         OP_AUG: begin
            cap_we = 1'b1;
            if (par_bit) begin
               cap_e_wd = ce_q + mf_ff;
               cap_o_wd = co_q - mf_ff;
            end else begin
               cap_e_wd = ce_q - mf_ff;
               cap_o_wd = co_q + mf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Edge memories, one entry per stored edge pair.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LINK_A) begin
         ends_a_mem[k_idx] <= item_a_ff;
         ends_b_mem[k_idx] <= item_b_ff;
         next_e_mem[k_idx] <= lh_q0;
         next_o_mem[k_idx] <= (item_a_ff == item_b_ff) ? {1'b0, k_idx, 1'b0} : lh_q1;
      end
      a_q  <= ends_a_mem[pair_ra];
      b_q  <= ends_b_mem[pair_ra];
      ne_q <= next_e_mem[pair_ra];
      no_q <= next_o_mem[pair_ra];
   end

   // Residual capacity banks, even and odd slots.
   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_e_mem[cap_wa] <= cap_e_wd;
         cap_o_mem[cap_wa] <= cap_o_wd;
      end
      ce_q <= cap_e_mem[pair_ra];
      co_q <= cap_o_mem[pair_ra];
   end

   // Adjacency list heads.
   always_ff @(posedge clock) begin
      if (lh_we) lh_mem[lh_wa] <= lh_wd;
      lh_q0 <= lh_mem[lh_ra0];
      lh_q1 <= lh_mem[b_idx];
   end

   // Search memories: visited marks, parent edges and the node queue.
   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      if (cmd.op == OP_VISIT && vis_take) par_mem[v_node] <= ei_ff[SW-1:0];
      if (q_we) q_mem[q_wa] <= q_wd;
      vis_q <= vis_mem[vis_ra];
      par_q <= par_mem[u_ff];
      q_q   <= q_mem[qh_ff[NW-1:0]];
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= NODE_COUNT_RESET;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   // Working registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff <= '0;
         flow_ff  <= '0;
         sweep_ff <= '0;
         qh_ff    <= '0;
         qt_ff    <= '0;
      end else begin
         case (cmd.op)
            OP_CLR_LIST: begin
               sweep_ff <= status.clr_last ? '0 : sweep_ff + NW'(1);
               edges_ff <= '0;
               flow_ff  <= '0;
            end
            OP_LINK_B: begin
               edges_ff <= edges_ff + CNTW'(1);
            end
            OP_CLR_VIS: begin
               sweep_ff <= status.vis_last ? '0 : sweep_ff + NW'(1);
               qh_ff    <= '0;
               qt_ff    <= (NW+1)'(1);
            end
            OP_POP: begin
               qh_ff <= qh_ff + (NW+1)'(1);
            end
            OP_VISIT: begin
               if (vis_take) qt_ff <= qt_ff + (NW+1)'(1);
            end
            OP_ADD: begin
               flow_ff <= flow_sum[FLOW_W] ? FLOW_MAX : flow_sum[FLOW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Payload registers for the item, edge walk and path walk.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_TAKE: begin
            item_a_ff    <= a_idx;
            item_b_ff    <= b_idx;
            item_c_ff    <= cap_sat;
            item_last_ff <= req_last_edge;
         end
         OP_FIRST: begin
            ei_ff <= lh_q0;
         end
         OP_VISIT: begin
            ei_ff <= next_sel;
         end
         OP_PATH_INIT: begin
            u_ff     <= sink;
            steps_ff <= '0;
            mf_ff    <= CAP_LIMIT;
         end
         OP_PATH_INIT2: begin
            u_ff     <= sink;
            steps_ff <= '0;
         end
         OP_CAP_RD: begin
            ei_ff <= {1'b0, par_q};
         end
         OP_MIN: begin
            if (cap_sel < mf_ff) mf_ff <= cap_sel;
            u_ff     <= tail_node;
            steps_ff <= steps_ff + (NW+1)'(1);
         end
         OP_AUG: begin
            u_ff     <= tail_node;
            steps_ff <= steps_ff + (NW+1)'(1);
         end
         default: begin
         end
      endcase
   end

   assign rsp_total_flow = flow_ff;

endmodule
